// ===== rtl/sabd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabd_pkg: shared types and constants
// Widths, scaling constants and display columns for the sample averaging and
// BCD display writer.
// ----------------------------------------------------------------------------
package sabd_pkg;

    localparam int unsigned SAMPLES_DEFAULT = 10;
    localparam int unsigned SAMPLES_MAX     = 16;

    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned SUM_W    = 12;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned AVG_W    = 8;

    // Reciprocal multiply used for the division by the sample count.
    localparam int unsigned RECIP_SHIFT = 24;
    localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;

    // Scaling by 330/256.
    localparam int unsigned SCALE_MUL   = 330;
    localparam int unsigned SCALE_SHIFT = 8;
    localparam int unsigned SCALED_W    = 9;
    localparam int unsigned SCALED_MAX  = 328;

    localparam int unsigned REM_W   = 7;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned HUND_W  = 2;

    // Multiply by 205 and shift by 11 divides values below 1029 by ten.
    localparam int unsigned TENS_MUL   = 205;
    localparam int unsigned TENS_SHIFT = 11;
    localparam int unsigned TENS_PROD_W = 15;

    localparam int unsigned COLUMN_W = 3;
    localparam int unsigned CHAR_W   = 6;

    localparam logic [COLUMN_W-1:0] COL_HUNDREDS = 3'd5;
    localparam logic [COLUMN_W-1:0] COL_TENS     = 3'd6;
    localparam logic [COLUMN_W-1:0] COL_UNITS    = 3'd7;
    localparam logic [CHAR_W-1:0]   ASCII_ZERO   = 6'd48;
    localparam logic [CHAR_W-1:0]   ASCII_NINE   = 6'd57;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = 1;
    localparam int unsigned QCNT_W      = 2;

    // One completed sum handed from the front end to the queue, or from the
    // queue head to the back end.
    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
    } sum_xfer_t;

endpackage

// ===== rtl/sabd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabd_front: sample accumulator
// Accepts samples, keeps the running sum and count, and pushes the sum of
// every completed group into the queue.
// ----------------------------------------------------------------------------
module sabd_front #(
    parameter int unsigned SAMPLES = sabd_pkg::SAMPLES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sabd_pkg::SAMPLE_W-1:0]  sample,
    input  logic                           q_full,
    output sabd_pkg::sum_xfer_t            push
);

    localparam int unsigned EFF = (SAMPLES < 1) ? 1 :
        ((SAMPLES > sabd_pkg::SAMPLES_MAX) ? sabd_pkg::SAMPLES_MAX : SAMPLES);
    localparam logic [sabd_pkg::CNT_W:0] EFF_CNT = (sabd_pkg::CNT_W + 1)'(EFF);

    logic [sabd_pkg::SUM_W-1:0] sum_reg, sum_next, sum_inc;
    logic [sabd_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [sabd_pkg::CNT_W:0]   cnt_inc;
    logic                       accept;
    logic                       done;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign sum_inc  = sum_reg + sabd_pkg::SUM_W'(sample);
    assign cnt_inc  = (sabd_pkg::CNT_W + 1)'(cnt_reg) + (sabd_pkg::CNT_W + 1)'(1);
    assign done     = (cnt_inc >= EFF_CNT);

    assign push.valid = accept && done;
    assign push.sum   = sum_inc;

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (done)
            begin
                sum_next = '0;
                cnt_next = '0;
            end
            else
            begin
                sum_next = sum_inc;
                cnt_next = cnt_inc[sabd_pkg::CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/sabd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabd_queue: completed-sum queue
// Two-entry queue that decouples the accumulator from the conversion
// pipeline.
// ----------------------------------------------------------------------------
module sabd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  sabd_pkg::sum_xfer_t push,
    output logic                q_full,
    output sabd_pkg::sum_xfer_t head,
    input  logic                pop
);

    logic [sabd_pkg::SUM_W-1:0]  mem_reg [sabd_pkg::QUEUE_DEPTH];
    logic [sabd_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [sabd_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [sabd_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic                        do_push;
    logic                        do_pop;

    assign q_full     = (cnt_reg == sabd_pkg::QCNT_W'(sabd_pkg::QUEUE_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.sum   = mem_reg[rd_ptr_reg];

    assign do_push = push.valid && !q_full;
    assign do_pop  = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + sabd_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + sabd_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + sabd_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - sabd_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/sabd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabd_back: average, scale, BCD split and digit writer
// Four-stage pipeline from a completed sum to three BCD digits, followed by
// a writer that emits one display digit per transaction.
// ----------------------------------------------------------------------------
module sabd_back #(
    parameter int unsigned SAMPLES = sabd_pkg::SAMPLES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sabd_pkg::sum_xfer_t            head,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sabd_pkg::COLUMN_W-1:0]  column,
    output logic [sabd_pkg::CHAR_W-1:0]    digit_char,
    output logic                           last
);

    localparam int unsigned EFF = (SAMPLES < 1) ? 1 :
        ((SAMPLES > sabd_pkg::SAMPLES_MAX) ? sabd_pkg::SAMPLES_MAX : SAMPLES);
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << sabd_pkg::RECIP_SHIFT) + EFF - 1) / EFF;
    localparam logic [sabd_pkg::RECIP_W-1:0] RECIP = sabd_pkg::RECIP_W'(RECIP_VAL);
    localparam int unsigned RPROD_W = sabd_pkg::SUM_W + sabd_pkg::RECIP_W;
    localparam int unsigned SPROD_W = sabd_pkg::AVG_W + sabd_pkg::SCALED_W;

    // Bit positions in the pending-write mask.
    localparam int unsigned P_HUND  = 0;
    localparam int unsigned P_TENS  = 1;
    localparam int unsigned P_UNITS = 2;

    logic adv;
    logic take_new;

    // Stage 1: average by reciprocal multiply.
    logic                          v1_reg;
    logic [RPROD_W-1:0]            recip_prod;
    logic [sabd_pkg::AVG_W-1:0]    avg_reg;

    // Stage 2: scale by 330/256.
    logic                          v2_reg;
    logic [SPROD_W-1:0]            scale_prod;
    logic [sabd_pkg::SCALED_W-1:0] scaled_reg;

    // Stage 3: hundreds digit and remainder.
    logic                          v3_reg;
    logic [sabd_pkg::HUND_W-1:0]   hund_next, hund3_reg;
    logic [sabd_pkg::SCALED_W-1:0] rem_full;
    logic [sabd_pkg::REM_W-1:0]    rem_reg;

    // Stage 4: tens and units digits.
    logic                              v4_reg;
    logic [sabd_pkg::TENS_PROD_W-1:0]  tens_prod;
    logic [sabd_pkg::DIGIT_W-1:0]      tens_next;
    logic [sabd_pkg::REM_W-1:0]        units_full;
    logic [sabd_pkg::HUND_W-1:0]       hund4_reg;
    logic [sabd_pkg::DIGIT_W-1:0]      tens4_reg;
    logic [sabd_pkg::DIGIT_W-1:0]      units4_reg;

    // Digit writer.
    logic [2:0]                    pend_reg, pend_next, pend_after, pend_new;
    logic [sabd_pkg::HUND_W-1:0]   hund_reg;
    logic [sabd_pkg::DIGIT_W-1:0]  tens_reg;
    logic [sabd_pkg::DIGIT_W-1:0]  units_reg;
    logic [sabd_pkg::DIGIT_W-1:0]  sel_digit;
    logic                          out_accept;

    assign adv = !v4_reg || take_new;
    assign pop = adv && head.valid;

    assign recip_prod = RPROD_W'(head.sum) * RPROD_W'(RECIP);
    assign scale_prod = SPROD_W'(avg_reg) * SPROD_W'(sabd_pkg::SCALE_MUL);

    always_comb
    begin
        if (scaled_reg >= sabd_pkg::SCALED_W'(300))
        begin
            hund_next = 2'd3;
            rem_full  = scaled_reg - sabd_pkg::SCALED_W'(300);
        end
        else if (scaled_reg >= sabd_pkg::SCALED_W'(200))
        begin
            hund_next = 2'd2;
            rem_full  = scaled_reg - sabd_pkg::SCALED_W'(200);
        end
        else if (scaled_reg >= sabd_pkg::SCALED_W'(100))
        begin
            hund_next = 2'd1;
            rem_full  = scaled_reg - sabd_pkg::SCALED_W'(100);
        end
        else
        begin
            hund_next = 2'd0;
            rem_full  = scaled_reg;
        end
    end

    assign tens_prod  = sabd_pkg::TENS_PROD_W'(rem_reg) *
                        sabd_pkg::TENS_PROD_W'(sabd_pkg::TENS_MUL);
    assign tens_next  = tens_prod[sabd_pkg::TENS_SHIFT +: sabd_pkg::DIGIT_W];
    assign units_full = rem_reg - sabd_pkg::REM_W'({tens_next, 3'b000})
                                - sabd_pkg::REM_W'({tens_next, 1'b0});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            avg_reg    <= recip_prod[sabd_pkg::RECIP_SHIFT +: sabd_pkg::AVG_W];
            scaled_reg <= scale_prod[sabd_pkg::SCALE_SHIFT +: sabd_pkg::SCALED_W];
            hund3_reg  <= hund_next;
            rem_reg    <= rem_full[sabd_pkg::REM_W-1:0];
            hund4_reg  <= hund3_reg;
            tens4_reg  <= tens_next;
            units4_reg <= units_full[sabd_pkg::DIGIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= head.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // The writer walks the pending mask from hundreds to units. A new reading
    // is loaded in the same cycle that the previous one finishes.
    assign out_valid  = (pend_reg != '0);
    assign out_accept = out_valid && out_ready;
    assign pend_after = out_accept ? (pend_reg & (pend_reg - 3'd1)) : pend_reg;
    assign take_new   = (pend_after == '0);

    always_comb
    begin
        pend_new          = '0;
        pend_new[P_UNITS] = 1'b1;
        pend_new[P_TENS]  = (tens4_reg != '0) || (hund4_reg != '0);
        pend_new[P_HUND]  = (hund4_reg != '0);
        pend_next = pend_after;
        if (take_new && v4_reg)
        begin
            pend_next = pend_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_new && v4_reg)
        begin
            hund_reg  <= hund4_reg;
            tens_reg  <= tens4_reg;
            units_reg <= units4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_comb
    begin
        if (pend_reg[P_HUND])
        begin
            column    = sabd_pkg::COL_HUNDREDS;
            sel_digit = sabd_pkg::DIGIT_W'(hund_reg);
            last      = 1'b0;
        end
        else if (pend_reg[P_TENS])
        begin
            column    = sabd_pkg::COL_TENS;
            sel_digit = tens_reg;
            last      = 1'b0;
        end
        else
        begin
            column    = sabd_pkg::COL_UNITS;
            sel_digit = units_reg;
            last      = 1'b1;
        end
    end

    assign digit_char = sabd_pkg::ASCII_ZERO + sabd_pkg::CHAR_W'(sel_digit);

`ifndef SYNTHESIS
    a_last_on_units: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (column == sabd_pkg::COL_UNITS)))
        else $error("last flag does not match the units column");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digit_char >= sabd_pkg::ASCII_ZERO &&
                       digit_char <= sabd_pkg::ASCII_NINE))
        else $error("digit character outside 0..9");

    a_scaled_range: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (scaled_reg <= sabd_pkg::SCALED_W'(sabd_pkg::SCALED_MAX)))
        else $error("scaled reading out of range");

    a_units_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg != '0) |-> pend_reg[P_UNITS])
        else $error("pending reading lacks its units write");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_accept && last && !v4_reg) |=> !out_valid)
        else $error("writer stays busy after the final write");
`endif

endmodule

// ===== rtl/sample_average_scale_bcd_display.sv =====
`timescale 1ns / 1ps
// The sample that completes a group reaches its first digit write through the queue,
// the four pipeline stages and the writer register. Throughput: one sample per cycle
// while the queue has room; each completed group emits one to three writes at one per
// cycle, so samples are never held up while SAMPLES >= 3 and the output keeps up.
// Reset clears the running sum, the sample count, the queue and all pipeline valid bits.
// ----------------------------------------------------------------------------
// sample_average_scale_bcd_display: averaged reading to display digits
// Averages groups of converter samples, scales the mean by 330/256 and writes
// the result as up to three ASCII digits to display columns 5 to 7.
// ----------------------------------------------------------------------------
module sample_average_scale_bcd_display #(
    parameter int unsigned SAMPLES = sabd_pkg::SAMPLES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sabd_pkg::SAMPLE_W-1:0]  sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sabd_pkg::COLUMN_W-1:0]  column,
    output logic [sabd_pkg::CHAR_W-1:0]    digit_char,
    output logic                           last
);

    sabd_pkg::sum_xfer_t push;
    sabd_pkg::sum_xfer_t head;
    logic                q_full;
    logic                pop;

    sabd_front #(
        .SAMPLES (SAMPLES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sample   (sample),
        .q_full   (q_full),
        .push     (push)
    );

    sabd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .q_full (q_full),
        .head   (head),
        .pop    (pop)
    );

    sabd_back #(
        .SAMPLES (SAMPLES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .column     (column),
        .digit_char (digit_char),
        .last       (last)
    );

endmodule
